/* design/lcd_pkg.sv */
package lcd_pkg;
  localparam int unsigned NodeCountDef      = 1024;
  localparam int unsigned MaxBlockDef       = 8;
  localparam int unsigned MaxConstraintsDef = 256;
  localparam int unsigned MaxEntriesDef     = 1024;

  localparam int unsigned ValW = 32;
  localparam int unsigned BsW  = 4;
  localparam int unsigned CcW  = 9;

  typedef enum logic [2:0] {
    ActWrite   = 3'd0,
    ActRead    = 3'd1,
    ActLoadCon = 3'd2,
    ActLoadEnt = 3'd3,
    ActFwd     = 3'd4,
    ActRev     = 3'd5
  } action_e;

  localparam logic RegBlockSize = 1'b0;
  localparam logic RegConCount  = 1'b1;

  // multiply-accumulate request into the shared unit
  typedef struct packed {
    logic signed [31:0] acc;
    logic signed [31:0] weight;
    logic signed [31:0] value;
  } mac_req_t;
endpackage

/* design/lcd_mac.sv */
// Shared rounding multiply-accumulate: acc + round(w*x / 2^16), clamped.
// Two stages: product register, then round and clamp.
module lcd_mac (
  input  logic              clk_i,
  input  lcd_pkg::mac_req_t req_i,
  output logic signed [31:0] sum_o,
  output logic              sat_o
);
  import lcd_pkg::*;

  logic signed [63:0] prod_q;
  logic signed [31:0] acc_q;
  logic signed [48:0] rnd;
  logic signed [49:0] s;

  always_ff @(posedge clk_i) begin
    prod_q <= 64'(req_i.weight) * 64'(req_i.value);
    acc_q  <= req_i.acc;
  end

  // floor((p + 2^15) / 2^16)
  assign rnd = 49'((prod_q + 64'sd32768) >>> 16);
  assign s   = 50'(acc_q) + 50'(rnd);

  always_comb begin
    sat_o = 1'b0;
    sum_o = s[31:0];
    if (s > 50'sd2147483647) begin
      sat_o = 1'b1;
      sum_o = 32'sh7fffffff;
    end else if (s < -50'sd2147483648) begin
      sat_o = 1'b1;
      sum_o = 32'sh80000000;
    end
  end
endmodule

/* design/linear_constraint_distributor_top.sv */
// Affine constraint distributor. Write, read and load items pass through a
// write/read state and an output state before the result appears. A pass
// walks constraints in order; a constraint whose row is out of range, or a
// block size of zero, skips it. Each component walks its entries (table read,
// element read, range check, operand hold, multiply-accumulate, write-back);
// an entry out of range is skipped after its range check.
// All of this goes through one shared multiply-accumulate unit and one write
// port and one read port of the vector memory. Ready is low while an item is
// at work or its result waits to be taken. Memories are not cleared after reset.
module linear_constraint_distributor_top #(
  parameter int unsigned NODE_COUNT      = lcd_pkg::NodeCountDef,
  parameter int unsigned MAX_BLOCK       = lcd_pkg::MaxBlockDef,
  parameter int unsigned MAX_CONSTRAINTS = lcd_pkg::MaxConstraintsDef,
  parameter int unsigned MAX_ENTRIES     = lcd_pkg::MaxEntriesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [8:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         action_i,
  input  logic [9:0]         node_i,
  input  logic [2:0]         component_i,
  input  logic signed [31:0] data_value_i,
  input  logic [7:0]         slot_i,
  input  logic [9:0]         entry_i,
  input  logic [10:0]        length_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] read_data_o,
  output logic               saturated_o
);
  import lcd_pkg::*;

  localparam int unsigned VDepth = NODE_COUNT * MAX_BLOCK;
  localparam int unsigned VaW = $clog2(VDepth);
  localparam int unsigned KW  = (MAX_CONSTRAINTS > 1) ? $clog2(MAX_CONSTRAINTS) : 1;
  localparam int unsigned EW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned BW  = $clog2(MAX_BLOCK + 1) + 1;
  localparam int unsigned KCW = $clog2(MAX_CONSTRAINTS + 1) + 1;

  // sequencer states
  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SRdWt  = 4'd1;
  localparam logic [3:0] SOut   = 4'd2;
  localparam logic [3:0] SKRd   = 4'd3;
  localparam logic [3:0] SKChk  = 4'd4;
  localparam logic [3:0] SComp  = 4'd5;
  localparam logic [3:0] SERd   = 4'd6;
  localparam logic [3:0] SEChk  = 4'd7;
  localparam logic [3:0] SVRd   = 4'd8;
  localparam logic [3:0] SVWt   = 4'd9;
  localparam logic [3:0] SMac1  = 4'd10;
  localparam logic [3:0] SMac2  = 4'd11;
  localparam logic [3:0] SClr   = 4'd12;
  localparam logic [3:0] SRead1 = 4'd13;
  localparam logic [3:0] SAcc   = 4'd14;

  logic [3:0]  state_q, state_d;
  logic [3:0]  bs_q;
  logic [8:0]  cc_q;

  // memories
  logic signed [31:0] vmem [VDepth];
  logic [9:0]         cnode_mem [MAX_CONSTRAINTS];
  logic [9:0]         cfirst_mem [MAX_CONSTRAINTS];
  logic [10:0]        ccount_mem [MAX_CONSTRAINTS];
  logic signed [31:0] coff_mem [MAX_CONSTRAINTS];
  logic [9:0]         par_mem [MAX_ENTRIES];
  logic signed [31:0] wt_mem [MAX_ENTRIES];

  logic signed [31:0] vrd_q;
  logic [9:0]  kn_q, kf_q, par_q;
  logic [10:0] kl_q;
  logic signed [31:0] ko_q, w_q;

  logic [2:0]  act_q;
  logic [9:0]  node_q;
  logic [2:0]  comp_q;
  logic signed [31:0] data_q;
  logic [7:0]  slot_q;
  logic [9:0]  entry_q;
  logic [10:0] len_q;

  logic [KCW-1:0] k_q;
  logic [BW-1:0]  c_q;
  logic [10:0]    i_q;
  logic           fwd_q, sat_q;
  logic signed [31:0] rowv_q, rd_q;
  logic               ovld_q;

  logic [BW-1:0]  bs_eff;
  logic [KCW-1:0] cc_eff;
  logic [10:0]    e_full;
  logic [EW-1:0]  e_idx;
  logic           e_ok, par_ok, row_ok;
  logic [VaW-1:0] row_a, par_a, in_a;
  logic           in_ok;

  mac_req_t           mreq;
  logic signed [31:0] msum;
  logic               msat;

  // vector memory port control
  logic               v_we;
  logic [VaW-1:0]     v_wa, v_ra;
  logic signed [31:0] v_wd;

  always_comb begin
    bs_eff = (BW'(bs_q) > BW'(MAX_BLOCK)) ? BW'(MAX_BLOCK) : BW'(bs_q);
    cc_eff = (KCW'(cc_q) > KCW'(MAX_CONSTRAINTS)) ? KCW'(MAX_CONSTRAINTS) : KCW'(cc_q);
    e_full = 11'(kf_q) + i_q;
    e_ok   = 32'(e_full) < MAX_ENTRIES;
    e_idx  = e_full[EW-1:0];
    par_ok = 32'(par_q) < NODE_COUNT;
    row_ok = 32'(kn_q) < NODE_COUNT;
    row_a  = VaW'(32'(kn_q) * MAX_BLOCK + 32'(c_q));
    par_a  = VaW'(32'(par_q) * MAX_BLOCK + 32'(c_q));
    in_ok  = 32'(node_q) < NODE_COUNT && 32'(comp_q) < MAX_BLOCK;
    in_a   = VaW'(32'(node_q) * MAX_BLOCK + 32'(comp_q));
  end

  assign in_ready_o  = (state_q == SIdle) && !ovld_q;
  assign out_valid_o = ovld_q;
  assign read_data_o = rd_q;
  assign saturated_o = sat_q;

  // read address: the row element before a component, the parent element
  // held steady until the multiply-accumulate has taken it
  always_comb begin
    v_ra = in_a;
    case (state_q)
      SComp: v_ra = row_a;
      SEChk, SVRd, SVWt, SAcc, SMac1: v_ra = par_a;
      default: v_ra = in_a;
    endcase
  end

  always_comb begin
    mreq.acc    = fwd_q ? rowv_q : vrd_q;
    mreq.weight = w_q;
    mreq.value  = fwd_q ? vrd_q : rowv_q;
  end

  lcd_mac u_mac (
    .clk_i (clk_i),
    .req_i (mreq),
    .sum_o (msum),
    .sat_o (msat)
  );

  always_comb begin
    v_we = 1'b0;
    v_wa = row_a;
    v_wd = msum;
    case (state_q)
      SRdWt: begin
        v_we = (act_q == ActWrite) && in_ok;
        v_wa = in_a;
        v_wd = data_q;
      end
      SRead1: begin
        // forward: the row starts from the offset before any parent is read
        v_we = fwd_q;
        v_wd = ko_q;
      end
      SMac2: begin
        v_we = 1'b1;
        v_wa = fwd_q ? row_a : par_a;
      end
      SClr: begin
        v_we = 1'b1;
        v_wd = fwd_q ? rowv_q : '0;
      end
      default: v_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (v_we) vmem[v_wa] <= v_wd;
    vrd_q <= vmem[v_ra];
    if (state_q == SKRd) begin
      kn_q <= cnode_mem[k_q[KW-1:0]];
      kf_q <= cfirst_mem[k_q[KW-1:0]];
      kl_q <= ccount_mem[k_q[KW-1:0]];
      ko_q <= coff_mem[k_q[KW-1:0]];
    end
    par_q <= par_mem[e_idx];
    w_q   <= wt_mem[e_idx];
    if (state_q == SRdWt && act_q == ActLoadCon && 32'(slot_q) < MAX_CONSTRAINTS) begin
      cnode_mem[slot_q[KW-1:0]]  <= node_q;
      cfirst_mem[slot_q[KW-1:0]] <= entry_q;
      ccount_mem[slot_q[KW-1:0]] <= len_q;
      coff_mem[slot_q[KW-1:0]]   <= data_q;
    end
    if (state_q == SRdWt && act_q == ActLoadEnt && 32'(entry_q) < MAX_ENTRIES) begin
      par_mem[entry_q[EW-1:0]] <= node_q;
      wt_mem[entry_q[EW-1:0]]  <= data_q;
    end
  end

  // hold the accepted item
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      act_q   <= action_i;
      node_q  <= node_i;
      comp_q  <= component_i;
      data_q  <= data_value_i;
      slot_q  <= slot_i;
      entry_q <= entry_i;
      len_q   <= length_i;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      SIdle:  if (in_valid_i && in_ready_o) state_d = SRdWt;
      SRdWt: begin
        if (act_q == ActFwd || act_q == ActRev) state_d = SKRd;
        else state_d = SOut;
      end
      SKRd:   state_d = (k_q < cc_eff) ? SKChk : SOut;
      SKChk:  state_d = (row_ok && bs_eff != '0) ? SComp : SKRd;
      SComp:  state_d = (c_q < bs_eff) ? SRead1 : SKRd;
      SRead1: state_d = SERd;
      SERd:   state_d = (i_q < kl_q) ? SEChk : SClr;
      SEChk:  state_d = SVRd;
      SVRd:   state_d = (e_ok && par_ok) ? SVWt : SERd;
      SVWt:   state_d = SAcc;
      SAcc:   state_d = SMac1;
      SMac1:  state_d = SMac2;
      SMac2:  state_d = SERd;
      SClr:   state_d = SComp;
      SOut:   state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      bs_q    <= 4'd1;
      cc_q    <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        if (cfg_index_i == RegBlockSize) bs_q <= cfg_data_i[3:0];
        else cc_q <= cfg_data_i;
      end
      if (state_q == SOut) ovld_q <= 1'b1;
      else if (out_ready_i) ovld_q <= 1'b0;
    end
  end

  // walk counters and row value
  always_ff @(posedge clk_i) begin
    case (state_q)
      SRdWt: begin
        k_q   <= '0;
        fwd_q <= (act_q == ActFwd);
        sat_q <= 1'b0;
        rd_q  <= '0;
      end
      SKChk: begin
        k_q <= k_q + 1'b1;
        c_q <= '0;
      end
      SComp: begin
        i_q <= '0;
      end
      SRead1: begin
        // forward starts from the offset; reverse reads the row element
        if (fwd_q) rowv_q <= ko_q;
        else rowv_q <= vrd_q;
      end
      SVRd: if (!(e_ok && par_ok)) i_q <= i_q + 1'b1;
      SMac2: begin
        i_q <= i_q + 1'b1;
        if (msat) sat_q <= 1'b1;
        // a parent that is the row itself changes the row value too
        if (fwd_q || par_a == row_a) rowv_q <= msum;
      end
      SClr: c_q <= c_q + 1'b1;
      SOut: begin
        if (act_q == ActRead && in_ok) rd_q <= vrd_q;
        if (!(act_q == ActFwd || act_q == ActRev)) sat_q <= 1'b0;
      end
      default: ;
    endcase
  end

  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> state_q == SIdle) else $error("ready while busy");
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o) else $error("second item taken");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(read_data_o))
    else $error("result dropped");
endmodule

/* tb/linear_constraint_distributor_top_tb.sv */
`timescale 1ns / 1ps

module linear_constraint_distributor_top_tb;
  import lcd_pkg::*;

  // Action codes outside the block's set; the block must answer them with zeros.
  localparam logic [2:0] ActSpareLo = 3'd6;
  localparam logic [2:0] ActSpareHi = 3'd7;

  localparam int unsigned Nodes   = NodeCountDef;
  localparam int unsigned Comps   = MaxBlockDef;
  localparam int unsigned Slots   = MaxConstraintsDef;
  localparam int unsigned Entries = MaxEntriesDef;
  localparam int unsigned Elems   = Nodes * Comps;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  typedef struct {
    logic [2:0]  action;
    logic [9:0]  node;
    logic [2:0]  comp;
    logic [31:0] data;
    logic [7:0]  slot;
    logic [9:0]  entry;
    logic [10:0] length;
  } lcd_item_t;

  typedef struct {
    logic [31:0] rd;
    logic        sat;
  } lcd_result_t;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk_i = ~clk_i;

  // Block inputs, all known from time zero
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_data  = '0;
  logic        in_valid_r = 1'b0;
  logic [2:0]  action_r  = '0;
  logic [9:0]  node_r    = '0;
  logic [2:0]  comp_r    = '0;
  logic [31:0] data_r    = '0;
  logic [7:0]  slot_r    = '0;
  logic [9:0]  entry_r   = '0;
  logic [10:0] length_r  = '0;
  logic        out_ready_r = 1'b0;

  logic               in_ready_o;
  logic               out_valid_o;
  logic signed [31:0] read_data_o;
  logic               saturated_o;

  linear_constraint_distributor_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid_r),
    .in_ready_o   (in_ready_o),
    .action_i     (action_r),
    .node_i       (node_r),
    .component_i  (comp_r),
    .data_value_i (data_r),
    .slot_i       (slot_r),
    .entry_i      (entry_r),
    .length_i     (length_r),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_r),
    .read_data_o  (read_data_o),
    .saturated_o  (saturated_o)
  );

  // Shadow copy of the block's memories, tables and registers. The *_ok flags
  // mark what has been written, so that stimulus never reads undefined state.
  logic signed [31:0] elem_m  [Elems];
  bit                 elem_ok [Elems];
  logic [9:0]         row_m   [Slots];
  logic [9:0]         first_m [Slots];
  logic [10:0]        len_m   [Slots];
  logic signed [31:0] off_m   [Slots];
  bit                 con_ok  [Slots];
  logic [9:0]         par_m   [Entries];
  logic signed [31:0] wgt_m   [Entries];
  bit                 ent_ok  [Entries];
  int unsigned        bs_m = 1;
  int unsigned        cc_m = 0;

  lcd_item_t   pending_q  [$];
  lcd_result_t expected_q [$];

  // Rough cycle cost of the queued work; the timeout is scaled from it.
  longint budget = 0;
  int     errors = 0;
  int     checked = 0;
  int     items_sent = 0;
  int     passes = 0;
  int     sat_seen = 0;
  bit     quiet = 1'b0;
  longint cycles = 0;

  // Add a rounded Q16.16 product to an accumulator; flag bit on top says clamped.
  function automatic logic [32:0] mac(logic signed [31:0] acc, logic signed [31:0] w,
                                      logic signed [31:0] x);
    longint p;
    longint s;
    logic   f;
    p = longint'(w) * longint'(x) + 32768;
    p = p >>> 16;
    s = longint'(acc) + p;
    f = 1'b0;
    if (s > QMax) begin
      s = QMax;
      f = 1'b1;
    end else if (s < QMin) begin
      s = QMin;
      f = 1'b1;
    end
    return {f, s[31:0]};
  endfunction

  // Apply every active constraint in order, forward or reverse.
  task automatic distribute(input bit fwd, output logic flag);
    int unsigned nb;
    int unsigned nc;
    int unsigned ra;
    int unsigned pa;
    int unsigned e;
    logic [32:0] r;
    nb = (bs_m > Comps) ? Comps : bs_m;
    nc = (cc_m > Slots) ? Slots : cc_m;
    flag = 1'b0;
    budget += 2;
    for (int k = 0; k < nc; k++) begin
      budget += 2 + nb * (2 + 8 * len_m[k]);
      for (int c = 0; c < nb; c++) begin
        ra = row_m[k] * Comps + c;
        if (fwd) begin
          elem_m[ra]  = off_m[k];
          elem_ok[ra] = 1'b1;
        end
        for (int i = 0; i < len_m[k]; i++) begin
          e = first_m[k] + i;
          if (e >= Entries) continue;
          pa = par_m[e] * Comps + c;
          if (fwd) begin
            r = mac(elem_m[ra], wgt_m[e], elem_m[pa]);
            elem_m[ra] = r[31:0];
          end else begin
            r = mac(elem_m[pa], wgt_m[e], elem_m[ra]);
            elem_m[pa] = r[31:0];
          end
          flag |= r[32];
        end
        if (!fwd) elem_m[ra] = '0;
      end
    end
  endtask

  // Predict the result of an item in sequence order and queue both.
  task automatic queue_item(input lcd_item_t it);
    lcd_result_t res;
    int unsigned addr;
    addr = it.node * Comps + it.comp;
    res.rd  = '0;
    res.sat = 1'b0;
    budget += 40;
    case (it.action)
      ActWrite: begin
        elem_m[addr]  = it.data;
        elem_ok[addr] = 1'b1;
      end
      ActRead: res.rd = elem_m[addr];
      ActLoadCon: begin
        row_m[it.slot]   = it.node;
        first_m[it.slot] = it.entry;
        len_m[it.slot]   = it.length;
        off_m[it.slot]   = it.data;
        con_ok[it.slot]  = 1'b1;
      end
      ActLoadEnt: begin
        par_m[it.entry]  = it.node;
        wgt_m[it.entry]  = it.data;
        ent_ok[it.entry] = 1'b1;
      end
      ActFwd: begin
        distribute(1'b1, res.sat);
        passes++;
      end
      ActRev: begin
        distribute(1'b0, res.sat);
        passes++;
      end
      default: ;
    endcase
    if (res.sat) sat_seen++;
    pending_q.push_back(it);
    expected_q.push_back(res);
  endtask

  // Fields that an action ignores still carry random bits.
  function automatic lcd_item_t rand_item();
    lcd_item_t it;
    it.action = ActSpareLo;
    it.node   = $urandom_range(0, 1023);
    it.comp   = $urandom_range(0, 7);
    it.data   = $urandom;
    it.slot   = $urandom_range(0, 255);
    it.entry  = $urandom_range(0, 1023);
    it.length = $urandom_range(0, 2047);
    return it;
  endfunction

  function automatic logic [9:0] pick_node();
    return ($urandom_range(0, 4) != 0) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return 32'h7fff_ffff;
    if (r < 20) return 32'h8000_0000;
    if (r < 25) return ($urandom_range(0, 1) != 0) ? 32'h0 : 32'hffff_ffff;
    if (r < 60) return $urandom;
    return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
  endfunction

  function automatic logic [31:0] pick_weight();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return 32'h7fff_ffff;
    if (r < 10) return 32'h8000_0000;
    if (r < 30) return $urandom;
    return $urandom_range(0, 32'h4_0000) - 32'h2_0000;
  endfunction

  task automatic put_write(input logic [9:0] n, input logic [2:0] c, input logic [31:0] v);
    lcd_item_t it;
    it = rand_item();
    it.action = ActWrite;
    it.node = n;
    it.comp = c;
    it.data = v;
    queue_item(it);
  endtask

  task automatic put_read(input logic [9:0] n, input logic [2:0] c);
    lcd_item_t it;
    it = rand_item();
    it.action = ActRead;
    it.node = n;
    it.comp = c;
    queue_item(it);
  endtask

  task automatic put_con(input logic [7:0] s, input logic [9:0] n, input logic [9:0] f,
                         input logic [10:0] l, input logic [31:0] v);
    lcd_item_t it;
    it = rand_item();
    it.action = ActLoadCon;
    it.slot = s;
    it.node = n;
    it.entry = f;
    it.length = l;
    it.data = v;
    queue_item(it);
  endtask

  task automatic put_ent(input logic [9:0] e, input logic [9:0] n, input logic [31:0] w);
    lcd_item_t it;
    it = rand_item();
    it.action = ActLoadEnt;
    it.entry = e;
    it.node = n;
    it.data = w;
    queue_item(it);
  endtask

  task automatic put_op(input logic [2:0] a);
    lcd_item_t it;
    it = rand_item();
    it.action = a;
    queue_item(it);
  endtask

  task automatic put_random_con(input logic [7:0] s);
    logic [9:0]  f;
    logic [10:0] l;
    f = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 63) : $urandom_range(0, 1023);
    l = ($urandom_range(0, 6) != 0) ? $urandom_range(0, 4) : $urandom_range(5, 12);
    put_con(s, pick_node(), f, l, pick_value());
  endtask

  task automatic ensure_node(input logic [9:0] n);
    for (int c = 0; c < Comps; c++)
      if (!elem_ok[n * Comps + c]) put_write(n, c, pick_value());
  endtask

  // Fill whatever an upcoming pass would read, so that it sees defined state only.
  task automatic prepare_pass();
    int unsigned nc;
    int unsigned e;
    nc = (cc_m > Slots) ? Slots : cc_m;
    for (int k = 0; k < nc; k++) begin
      if (!con_ok[k]) put_random_con(k);
      ensure_node(row_m[k]);
      for (int i = 0; i < len_m[k]; i++) begin
        e = first_m[k] + i;
        if (e >= Entries) break;
        if (!ent_ok[e]) put_ent(e, pick_node(), pick_weight());
        ensure_node(par_m[e]);
      end
    end
  endtask

  task automatic random_items(input int n, input int pass_pct);
    int unsigned r;
    int unsigned a;
    bit          found;
    for (int j = 0; j < n; j++) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        put_write(pick_node(), $urandom_range(0, 7), pick_value());
      end else if (r < 55) begin
        found = 1'b0;
        for (int t = 0; t < 32 && !found; t++) begin
          a = (t < 16) ? $urandom_range(0, 255) : $urandom_range(0, Elems - 1);
          found = elem_ok[a];
        end
        if (found) put_read(a / Comps, a % Comps);
        else put_write(pick_node(), $urandom_range(0, 7), pick_value());
      end else if (r < 67) begin
        put_random_con(($urandom_range(0, 4) != 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, 255));
      end else if (r < 80) begin
        put_ent(($urandom_range(0, 2) != 0) ? $urandom_range(0, 63) : $urandom_range(0, 1023),
                pick_node(), pick_weight());
      end else if (r < 80 + pass_pct) begin
        prepare_pass();
        put_op(($urandom_range(0, 1) != 0) ? ActFwd : ActRev);
      end else if (r < 85 + pass_pct) begin
        put_op(($urandom_range(0, 1) != 0) ? ActSpareLo : ActSpareHi);
      end else begin
        put_write(pick_node(), $urandom_range(0, 7), pick_value());
      end
    end
  endtask

  // Hold until the block has drained and every expected result has come back.
  task automatic wait_idle();
    while (pending_q.size() != 0 || in_valid_r || expected_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic idx, input int unsigned v);
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v[8:0];
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    if (idx == RegBlockSize) bs_m = v & 32'hf;
    else cc_m = v & 32'h1ff;
  endtask

  task automatic set_config(input int unsigned bs, input int unsigned cc);
    wait_idle();
    cfg_write(RegBlockSize, bs);
    cfg_write(RegConCount, cc);
  endtask

  // Driver: present the next pending item, hold it until taken, idle in bursts.
  lcd_item_t cur;
  int        send_gap = 0;

  always @(posedge clk_i) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_valid_r || in_ready_o) begin
      if (in_valid_r) items_sent++;
      if (send_gap != 0) begin
        send_gap--;
        in_valid_r <= 1'b0;
      end else if (pending_q.size() != 0) begin
        cur = pending_q.pop_front();
        action_r   <= cur.action;
        node_r     <= cur.node;
        comp_r     <= cur.comp;
        data_r     <= cur.data;
        slot_r     <= cur.slot;
        entry_r    <= cur.entry;
        length_r   <= cur.length;
        in_valid_r <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 15);
      end else begin
        in_valid_r <= 1'b0;
      end
    end
  end

  // Monitor: take results, compare against the oldest prediction, stall in bursts.
  lcd_result_t want;
  int          recv_stall = 0;

  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && out_ready_r) begin
      if (expected_q.size() == 0) begin
        $error("result with nothing expected: read_data %h saturated %b",
               read_data_o, saturated_o);
        errors++;
      end else begin
        want = expected_q.pop_front();
        checked++;
        if (read_data_o !== want.rd) begin
          $error("read_data: expected %h, got %h", want.rd, read_data_o);
          errors++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %b, got %b", want.sat, saturated_o);
          errors++;
        end
      end
    end
    if (quiet) begin
      out_ready_r <= 1'b1;
    end else if (recv_stall != 0) begin
      recv_stall--;
      out_ready_r <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      recv_stall = $urandom_range(1, 15);
      out_ready_r <= 1'b0;
    end else begin
      out_ready_r <= 1'b1;
    end
  end

  // Watchdog, scaled by the work queued so far.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > 4 * budget + 200000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_n <= 1'b1;

    // Directed: field extremes, every action, clamping, parent equal to row,
    // entries running off the end of the table.
    set_config(2, 2);
    put_write(10'd0, 3'd0, 32'h7fff_ffff);
    put_write(10'd0, 3'd1, 32'h8000_0000);
    put_write(10'd1023, 3'd7, 32'hffff_ffff);
    put_read(10'd0, 3'd0);
    put_read(10'd0, 3'd1);
    put_read(10'd1023, 3'd7);
    put_op(ActSpareLo);
    put_op(ActSpareHi);
    put_con(8'd255, 10'd1023, 10'd1023, 11'd1024, 32'h0);
    put_con(8'd254, 10'd1, 10'd1020, 11'd1023, 32'h7fff_ffff);
    put_ent(10'd1023, 10'd0, 32'h7fff_ffff);
    put_con(8'd0, 10'd2, 10'd0, 11'd2, 32'h0001_0000);
    put_ent(10'd0, 10'd0, 32'h7fff_ffff);
    put_ent(10'd1, 10'd2, 32'h0001_0000);
    put_con(8'd1, 10'd3, 10'd0, 11'd0, 32'h8000_0000);
    prepare_pass();
    put_op(ActFwd);
    put_read(10'd2, 3'd0);
    put_read(10'd2, 3'd1);
    put_read(10'd3, 3'd0);
    put_op(ActRev);
    put_read(10'd0, 3'd0);
    put_read(10'd0, 3'd1);
    put_read(10'd2, 3'd0);

    // Random phases across register settings, extremes included.
    set_config(1, 0);
    random_items(150, 8);
    set_config(8, 4);
    random_items(300, 8);
    set_config(0, 5);
    random_items(150, 8);
    set_config(15, 6);
    random_items(250, 6);
    set_config(3, 511);
    random_items(200, 2);
    set_config(4, 16);
    random_items(150, 8);
    // Hold the sender until every result is back, then carry on.
    wait_idle();
    random_items(150, 8);
    set_config(2, 256);
    random_items(100, 2);
    wait_idle();
    quiet = 1'b1;
    set_config(1, 1);
    random_items(200, 8);

    wait_idle();
    repeat (20) @(posedge clk_i);
    $display("Covered %0d items, %0d results checked, %0d passes (%0d clamped).",
             items_sent, checked, passes, sat_seen);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/lcd_pkg.sv
design/lcd_mac.sv
design/linear_constraint_distributor_top.sv
tb/linear_constraint_distributor_top_tb.sv
